// ===== design/mtl_pkg.sv =====
// Shared types, character codes and helper functions for the markup token lexer.
// Used by every module in the design folder; depends on nothing.
package mtl_pkg;

    localparam int RunSlots  = 3;
    localparam int RunDepth  = 4;
    localparam int RunPtrW   = $clog2(RunDepth);
    localparam int RunCountW = $clog2(RunDepth + 1);

    localparam logic [7:0] ChNul    = 8'h00;
    localparam logic [7:0] ChLf     = 8'h0A;
    localparam logic [7:0] ChLBrace = 8'h7B;
    localparam logic [7:0] ChRBrace = 8'h7D;
    localparam logic [7:0] ChLBrack = 8'h5B;
    localparam logic [7:0] ChRBrack = 8'h5D;
    localparam logic [7:0] ChEqual  = 8'h3D;
    localparam logic [7:0] ChHash   = 8'h23;
    localparam logic [7:0] ChBar    = 8'h7C;
    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChBang   = 8'h21;
    localparam logic [7:0] ChPlus   = 8'h2B;
    localparam logic [7:0] ChMinus  = 8'h2D;

    typedef enum logic [3:0] {
        KIND_ID      = 4'd0,
        KIND_LBRACE  = 4'd1,
        KIND_RBRACE  = 4'd2,
        KIND_LBRACK  = 4'd3,
        KIND_RBRACK  = 4'd4,
        KIND_EQ      = 4'd5,
        KIND_CONDEQ  = 4'd6,
        KIND_HASH    = 4'd7,
        KIND_BAR     = 4'd8,
        KIND_TEXT    = 4'd9,
        KIND_COMMENT = 4'd10,
        KIND_NEQ     = 4'd11,
        KIND_PLUSEQ  = 4'd12,
        KIND_MINUSEQ = 4'd13,
        KIND_END     = 4'd14,
        KIND_ERROR   = 4'd15
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_INVALID = 2'd1,
        ERR_UNTERM  = 2'd2,
        ERR_BANG    = 2'd3
    } err_t;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'd0,
        MODE_ID      = 4'd1,
        MODE_EQ      = 4'd2,
        MODE_Q1      = 4'd3,
        MODE_Q2      = 4'd4,
        MODE_STR     = 4'd5,
        MODE_TSTR    = 4'd6,
        MODE_BANG    = 4'd7,
        MODE_BANGWS  = 4'd8,
        MODE_CMT     = 4'd9,
        MODE_CMTDROP = 4'd10,
        MODE_PLUS    = 4'd11,
        MODE_MINUS   = 4'd12
    } mode_t;

    typedef struct packed {
        kind_t      kind;
        logic       has_char;
        logic [7:0] char_value;
        logic       token_end;
        err_t       error_code;
    } result_t;

    // One input word's worth of results, slot 0 first.
    typedef struct packed {
        logic [1:0]                   cnt;
        result_t [RunSlots-1:0]       slot;
    } run_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

    // Outcome of lexing a byte as the first byte of a new token.
    typedef struct packed {
        logic    emit;
        logic    fail;
        result_t res;
        mode_t   mode;
    } start_t;

    function automatic logic is_space(logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_alpha(logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    // Content results carry a byte; every other result ends its token.
    function automatic result_t mk(kind_t kind, logic has, logic [7:0] ch, err_t err);
        result_t r;
        r.kind       = kind;
        r.has_char   = has;
        r.char_value = has ? ch : 8'h00;
        r.token_end  = !has;
        r.error_code = err;
        return r;
    endfunction

    function automatic run_t run_add(run_t r, result_t x);
        run_t o;
        o = r;
        o.slot[o.cnt] = x;
        o.cnt = o.cnt + 2'd1;
        return o;
    endfunction

    function automatic start_t start_of(logic [7:0] b);
        start_t s;
        s.emit = 1'b0;
        s.fail = 1'b0;
        s.res  = mk(KIND_ID, 1'b0, 8'h00, ERR_NONE);
        s.mode = MODE_IDLE;
        if (is_space(b)) begin
            s.emit = 1'b0;
        end
        else if (is_alpha(b)) begin
            s.emit = 1'b1;
            s.res  = mk(KIND_ID, 1'b1, b, ERR_NONE);
            s.mode = MODE_ID;
        end
        else begin
            unique case (b)
                ChLBrace: begin s.emit = 1'b1; s.res = mk(KIND_LBRACE, 1'b0, b, ERR_NONE); end
                ChRBrace: begin s.emit = 1'b1; s.res = mk(KIND_RBRACE, 1'b0, b, ERR_NONE); end
                ChLBrack: begin s.emit = 1'b1; s.res = mk(KIND_LBRACK, 1'b0, b, ERR_NONE); end
                ChRBrack: begin s.emit = 1'b1; s.res = mk(KIND_RBRACK, 1'b0, b, ERR_NONE); end
                ChHash:   begin s.emit = 1'b1; s.res = mk(KIND_HASH, 1'b0, b, ERR_NONE); end
                ChBar:    begin s.emit = 1'b1; s.res = mk(KIND_BAR, 1'b0, b, ERR_NONE); end
                ChEqual:  s.mode = MODE_EQ;
                ChQuote:  s.mode = MODE_Q1;
                ChBang:   s.mode = MODE_BANG;
                ChPlus:   s.mode = MODE_PLUS;
                ChMinus:  s.mode = MODE_MINUS;
                default:
                begin
                    s.emit = 1'b1;
                    s.fail = 1'b1;
                    s.res  = mk(KIND_ERROR, 1'b0, b, ERR_INVALID);
                end
            endcase
        end
        return s;
    endfunction

endpackage

// ===== design/mtl_front.sv =====
// Front end of the lexer: accepts text words, runs the lexer state machine and
// builds the run of results for each word. Depends on mtl_pkg.
module mtl_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         char_byte,
    input  logic               end_of_text,
    input  mtl_pkg::fifo_stat_t stat,
    output logic               push,
    output mtl_pkg::run_t      run
);
    import mtl_pkg::*;

    mode_t      mode_reg, mode_next;
    logic [1:0] pq_reg, pq_next;
    logic       halted_reg, halted_next;
    logic       drop_reg;

    logic       accept;
    logic       eot;
    start_t     st;
    logic       is_q, is_lf, is_eq, is_sp;

    assign in_ready = !stat.full;
    assign accept   = in_valid && in_ready;
    assign eot      = end_of_text || (char_byte == ChNul);
    assign st       = start_of(char_byte);
    assign is_q     = (char_byte == ChQuote);
    assign is_lf    = (char_byte == ChLf);
    assign is_eq    = (char_byte == ChEqual);
    assign is_sp    = is_space(char_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pq_reg     <= 2'd0;
            halted_reg <= 1'b0;
            drop_reg   <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            pq_reg     <= pq_next;
            halted_reg <= halted_next;
            if (cfg_we)
            begin
                drop_reg <= cfg_wdata;
            end
        end
    end

    // Next state.
    always_comb
    begin
        mode_next   = mode_reg;
        pq_next     = pq_reg;
        halted_next = halted_reg;
        if (accept && eot)
        begin
            mode_next   = MODE_IDLE;
            pq_next     = 2'd0;
            halted_next = 1'b0;
        end
        else if (accept && !halted_reg)
        begin
            unique case (mode_reg)
                MODE_ID:
                begin
                    if (!is_alpha(char_byte))
                    begin
                        mode_next   = st.mode;
                        halted_next = st.fail;
                    end
                end
                MODE_EQ:
                begin
                    if (is_eq)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        mode_next   = st.mode;
                        halted_next = st.fail;
                    end
                end
                MODE_Q1:
                begin
                    if (is_q)
                    begin
                        mode_next = MODE_Q2;
                    end
                    else if (is_lf)
                    begin
                        mode_next   = MODE_IDLE;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        mode_next = MODE_STR;
                    end
                end
                MODE_Q2:
                begin
                    if (is_q)
                    begin
                        mode_next = MODE_TSTR;
                        pq_next   = 2'd0;
                    end
                    else
                    begin
                        mode_next   = st.mode;
                        halted_next = st.fail;
                    end
                end
                MODE_STR:
                begin
                    if (is_q)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if (is_lf)
                    begin
                        mode_next   = MODE_IDLE;
                        halted_next = 1'b1;
                    end
                end
                MODE_TSTR:
                begin
                    if (is_q)
                    begin
                        if (pq_reg != 2'd3)
                        begin
                            pq_next = pq_reg + 2'd1;
                        end
                    end
                    else if (pq_reg == 2'd3)
                    begin
                        pq_next     = 2'd0;
                        mode_next   = st.mode;
                        halted_next = st.fail;
                    end
                    else
                    begin
                        pq_next = 2'd0;
                    end
                end
                MODE_BANG, MODE_BANGWS:
                begin
                    if (is_eq && mode_reg == MODE_BANG)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if (is_sp)
                    begin
                        mode_next = MODE_BANGWS;
                    end
                    else if (char_byte == ChLBrace)
                    begin
                        mode_next = drop_reg ? MODE_CMTDROP : MODE_CMT;
                    end
                    else
                    begin
                        mode_next   = MODE_IDLE;
                        halted_next = 1'b1;
                    end
                end
                MODE_CMT, MODE_CMTDROP:
                begin
                    if (char_byte == ChRBrace)
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_PLUS, MODE_MINUS:
                begin
                    mode_next = MODE_IDLE;
                    if (!is_eq)
                    begin
                        halted_next = 1'b1;
                    end
                end
                MODE_IDLE:
                begin
                    mode_next   = st.mode;
                    halted_next = st.fail;
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end
    end

    // Results for the word being accepted.
    always_comb
    begin
        run = '0;
        if (eot)
        begin
            if (!halted_reg)
            begin
                unique case (mode_reg)
                    MODE_ID:   run = run_add(run, mk(KIND_ID, 1'b0, char_byte, ERR_NONE));
                    MODE_EQ:   run = run_add(run, mk(KIND_EQ, 1'b0, char_byte, ERR_NONE));
                    MODE_Q2:   run = run_add(run, mk(KIND_TEXT, 1'b0, char_byte, ERR_NONE));
                    MODE_Q1, MODE_STR:
                        run = run_add(run, mk(KIND_ERROR, 1'b0, char_byte, ERR_UNTERM));
                    MODE_TSTR:
                    begin
                        if (pq_reg == 2'd3)
                        begin
                            run = run_add(run, mk(KIND_TEXT, 1'b0, char_byte, ERR_NONE));
                        end
                        else
                        begin
                            run = run_add(run, mk(KIND_ERROR, 1'b0, char_byte, ERR_UNTERM));
                        end
                    end
                    MODE_BANG, MODE_BANGWS:
                        run = run_add(run, mk(KIND_ERROR, 1'b0, char_byte, ERR_BANG));
                    MODE_CMT:  run = run_add(run, mk(KIND_COMMENT, 1'b0, char_byte, ERR_NONE));
                    MODE_PLUS, MODE_MINUS:
                        run = run_add(run, mk(KIND_ERROR, 1'b0, char_byte, ERR_INVALID));
                    default:   run = run;
                endcase
            end
            run = run_add(run, mk(KIND_END, 1'b0, char_byte, ERR_NONE));
        end
        else if (!halted_reg)
        begin
            unique case (mode_reg)
                MODE_ID:
                begin
                    if (is_alpha(char_byte))
                    begin
                        run = run_add(run, mk(KIND_ID, 1'b1, char_byte, ERR_NONE));
                    end
                    else
                    begin
                        run = run_add(run, mk(KIND_ID, 1'b0, char_byte, ERR_NONE));
                        if (st.emit) run = run_add(run, st.res);
                    end
                end
                MODE_EQ:
                begin
                    if (is_eq)
                    begin
                        run = run_add(run, mk(KIND_CONDEQ, 1'b0, char_byte, ERR_NONE));
                    end
                    else
                    begin
                        run = run_add(run, mk(KIND_EQ, 1'b0, char_byte, ERR_NONE));
                        if (st.emit) run = run_add(run, st.res);
                    end
                end
                MODE_Q1:
                begin
                    if (is_lf)
                    begin
                        run = run_add(run, mk(KIND_ERROR, 1'b0, char_byte, ERR_UNTERM));
                    end
                    else if (!is_q)
                    begin
                        run = run_add(run, mk(KIND_TEXT, 1'b1, char_byte, ERR_NONE));
                    end
                end
                MODE_Q2:
                begin
                    if (!is_q)
                    begin
                        run = run_add(run, mk(KIND_TEXT, 1'b0, char_byte, ERR_NONE));
                        if (st.emit) run = run_add(run, st.res);
                    end
                end
                MODE_STR:
                begin
                    if (is_q)
                    begin
                        run = run_add(run, mk(KIND_TEXT, 1'b0, char_byte, ERR_NONE));
                    end
                    else if (is_lf)
                    begin
                        run = run_add(run, mk(KIND_ERROR, 1'b0, char_byte, ERR_UNTERM));
                    end
                    else
                    begin
                        run = run_add(run, mk(KIND_TEXT, 1'b1, char_byte, ERR_NONE));
                    end
                end
                MODE_TSTR:
                begin
                    if (is_q)
                    begin
                        if (pq_reg == 2'd3)
                        begin
                            run = run_add(run, mk(KIND_TEXT, 1'b1, ChQuote, ERR_NONE));
                        end
                    end
                    else if (pq_reg == 2'd3)
                    begin
                        run = run_add(run, mk(KIND_TEXT, 1'b0, char_byte, ERR_NONE));
                        if (st.emit) run = run_add(run, st.res);
                    end
                    else
                    begin
                        // Release the held-back quotes ahead of the byte.
                        if (pq_reg >= 2'd1) run = run_add(run, mk(KIND_TEXT, 1'b1, ChQuote, ERR_NONE));
                        if (pq_reg >= 2'd2) run = run_add(run, mk(KIND_TEXT, 1'b1, ChQuote, ERR_NONE));
                        run = run_add(run, mk(KIND_TEXT, 1'b1, char_byte, ERR_NONE));
                    end
                end
                MODE_BANG, MODE_BANGWS:
                begin
                    if (is_eq && mode_reg == MODE_BANG)
                    begin
                        run = run_add(run, mk(KIND_NEQ, 1'b0, char_byte, ERR_NONE));
                    end
                    else if (!is_sp && char_byte != ChLBrace)
                    begin
                        run = run_add(run, mk(KIND_ERROR, 1'b0, char_byte, ERR_BANG));
                    end
                end
                MODE_CMT:
                begin
                    if (char_byte == ChRBrace)
                    begin
                        run = run_add(run, mk(KIND_COMMENT, 1'b0, char_byte, ERR_NONE));
                    end
                    else
                    begin
                        run = run_add(run, mk(KIND_COMMENT, 1'b1, char_byte, ERR_NONE));
                    end
                end
                MODE_CMTDROP:
                begin
                    run = run;
                end
                MODE_PLUS, MODE_MINUS:
                begin
                    if (is_eq)
                    begin
                        run = run_add(run, mk((mode_reg == MODE_PLUS) ? KIND_PLUSEQ : KIND_MINUSEQ,
                                              1'b0, char_byte, ERR_NONE));
                    end
                    else
                    begin
                        run = run_add(run, mk(KIND_ERROR, 1'b0, char_byte, ERR_INVALID));
                    end
                end
                MODE_IDLE:
                begin
                    if (st.emit) run = run_add(run, st.res);
                end
                default:
                begin
                    run = run;
                end
            endcase
        end
    end

    assign push = accept && (run.cnt != 2'd0);

endmodule

// ===== design/mtl_run_fifo.sv =====
// Short queue of result runs between the lexer front and the output serializer.
// Depends on mtl_pkg.
module mtl_run_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mtl_pkg::run_t       push_run,
    input  logic                pop,
    output mtl_pkg::run_t       head,
    output mtl_pkg::fifo_stat_t stat
);
    import mtl_pkg::*;

    run_t                 entry_reg [RunDepth];
    logic [RunPtrW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [RunCountW-1:0] count_reg, count_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == RunCountW'(RunDepth));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_run;
        end
    end

endmodule

// ===== design/mtl_back.sv =====
// Back end of the lexer: walks the run at the queue head and hands out its
// results one word at a time. Depends on mtl_pkg.
module mtl_back (
    input  logic                clk,
    input  logic                rst_n,
    input  mtl_pkg::run_t       head,
    input  mtl_pkg::fifo_stat_t stat,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [3:0]          token_kind,
    output logic                has_char,
    output logic [7:0]          char_value,
    output logic                token_end,
    output logic [1:0]          error_code,
    output logic                last_of_run
);
    import mtl_pkg::*;

    logic [1:0] idx_reg, idx_next;
    result_t    cur;
    logic       take;

    assign cur         = head.slot[idx_reg];
    assign out_valid   = !stat.empty;
    assign take        = out_valid && out_ready;
    assign last_of_run = (idx_reg == head.cnt - 2'd1);
    assign pop         = take && last_of_run;

    assign token_kind  = cur.kind;
    assign has_char    = cur.has_char;
    assign char_value  = cur.char_value;
    assign token_end   = cur.token_end;
    assign error_code  = cur.error_code;

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
        begin
            idx_next = last_of_run ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

// ===== design/markup_token_lexer_core.sv =====
// Top level of the streaming markup token lexer: front, run queue and back.
// Depends on mtl_pkg, mtl_front, mtl_run_fifo and mtl_back.
//
// Usage:
//   Input channel (in_valid/in_ready, char_byte, end_of_text) takes one text
//   word per cycle unless the queue is full. A zero byte counts as end of
//   text. Each accepted word yields zero to three result words on the output
//   channel (out_valid/out_ready); last_of_run marks the final result word
//   of an input word. Words that yield nothing (whitespace, held-back
//   quotes, dropped comment bytes) leave no trace at the output.
//   The first result of a word is registered in the run queue before it
//   is offered. Throughput: one input word per cycle while each yields at
//   most one result; else the output side runs at one result per ready cycle
//   and the lexer state machine in the front is the only per-word loop.
//   A four-run queue parts the two sides: the front keeps accepting while
//   the receiver stalls until the queue fills, then drops in_ready.
//   cfg_we/cfg_wdata write drop_comments; write it only while idle.
//   Reset (rst_n low, asynchronous) returns the lexer to between-token mode,
//   clears held quotes, the halted flag, drop_comments and the queue.
module markup_token_lexer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_byte,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] token_kind,
    output logic       has_char,
    output logic [7:0] char_value,
    output logic       token_end,
    output logic [1:0] error_code,
    output logic       last_of_run
);
    import mtl_pkg::*;

    fifo_stat_t stat;
    run_t       push_run;
    run_t       head;
    logic       push;
    logic       pop;

    // Lex each accepted word into a run of results.
    mtl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_byte   (char_byte),
        .end_of_text (end_of_text),
        .stat        (stat),
        .push        (push),
        .run         (push_run)
    );

    // Hold runs until the output side takes them.
    mtl_run_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_run (push_run),
        .pop      (pop),
        .head     (head),
        .stat     (stat)
    );

    // Advance through the head run one result at a time.
    mtl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .stat        (stat),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .token_kind  (token_kind),
        .has_char    (has_char),
        .char_value  (char_value),
        .token_end   (token_end),
        .error_code  (error_code),
        .last_of_run (last_of_run)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full)
        else $error("run pushed into a full queue");

    a_char_xor_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (has_char != token_end))
        else $error("result both carries a byte and ends a token, or neither");

    a_error_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error_code != ERR_NONE) |-> (token_kind == KIND_ERROR))
        else $error("error code on a non-error result");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && token_kind == KIND_END) |-> last_of_run)
        else $error("end result not last of its run");

    a_pop_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (out_valid && last_of_run))
        else $error("queue popped before its run was delivered");

endmodule

// ===== tb/sv/markup_token_lexer_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for markup_token_lexer_core: random and directed text with token checks.
// Depends on mtl_pkg and the design; a scoreboard class predicts every result word.
module markup_token_lexer_core_test;
    import mtl_pkg::*;

    localparam int IdleLimit = 2000;  // cycles with no word moving on either side
    localparam int LongHold  = 80;    // receiver hold-off used to back up the run queue

    // One predicted result word.
    typedef struct {
        kind_t      kind;
        logic       has;
        logic [7:0] ch;
        logic       tend;
        err_t       err;
        logic       last;
    } lex_result_t;

    // Token scoreboard: mirrors the lexer state and holds the words still owed by the block.
    class token_scoreboard;
        lex_result_t expected_tokens[$];
        lex_result_t word_q[$];
        mode_t       lex_mode;
        logic [1:0]  quotes;
        logic        halted;
        logic        drop_cmt;
        int          errors;
        int          live_words;

        function new();
            lex_mode   = MODE_IDLE;
            quotes     = 2'd0;
            halted     = 1'b0;
            drop_cmt   = 1'b0;
            errors     = 0;
            live_words = 0;
        endfunction

        function bit blank(logic [7:0] b);
            return b inside {8'h20, [8'h09:8'h0D]};
        endfunction

        function bit letter(logic [7:0] b);
            return (b | 8'h20) inside {[8'h61:8'h7A]};
        endfunction

        function void add_byte(kind_t k, logic [7:0] ch);
            lex_result_t r;
            r.kind = k;
            r.has  = 1'b1;
            r.ch   = ch;
            r.tend = 1'b0;
            r.err  = ERR_NONE;
            r.last = 1'b0;
            word_q.push_back(r);
        endfunction

        function void add_mark(kind_t k, err_t e = ERR_NONE);
            lex_result_t r;
            r.kind = k;
            r.has  = 1'b0;
            r.ch   = 8'h00;
            r.tend = 1'b1;
            r.err  = e;
            r.last = 1'b0;
            word_q.push_back(r);
        endfunction

        // Report the error once, then discard bytes until end of text.
        function void add_error(err_t e);
            add_mark(KIND_ERROR, e);
            halted   = 1'b1;
            lex_mode = MODE_IDLE;
            quotes   = 2'd0;
        endfunction

        function void begin_token(logic [7:0] b);
            lex_mode = MODE_IDLE;
            if (blank(b))
                return;
            if (letter(b))
            begin
                add_byte(KIND_ID, b);
                lex_mode = MODE_ID;
                return;
            end
            case (b)
                ChLBrace: add_mark(KIND_LBRACE);
                ChRBrace: add_mark(KIND_RBRACE);
                ChLBrack: add_mark(KIND_LBRACK);
                ChRBrack: add_mark(KIND_RBRACK);
                ChHash:   add_mark(KIND_HASH);
                ChBar:    add_mark(KIND_BAR);
                ChEqual:  lex_mode = MODE_EQ;
                ChQuote:  lex_mode = MODE_Q1;
                ChBang:   lex_mode = MODE_BANG;
                ChPlus:   lex_mode = MODE_PLUS;
                ChMinus:  lex_mode = MODE_MINUS;
                default:  add_error(ERR_INVALID);
            endcase
        endfunction

        function void take_byte(logic [7:0] b);
            case (lex_mode)
                MODE_ID:
                    if (letter(b))
                        add_byte(KIND_ID, b);
                    else
                    begin
                        add_mark(KIND_ID);
                        begin_token(b);
                    end
                MODE_EQ:
                    if (b == ChEqual)
                    begin
                        add_mark(KIND_CONDEQ);
                        lex_mode = MODE_IDLE;
                    end
                    else
                    begin
                        add_mark(KIND_EQ);
                        begin_token(b);
                    end
                MODE_Q1:
                    if (b == ChQuote)
                        lex_mode = MODE_Q2;
                    else if (b == ChLf)
                        add_error(ERR_UNTERM);
                    else
                    begin
                        add_byte(KIND_TEXT, b);
                        lex_mode = MODE_STR;
                    end
                MODE_Q2:
                    if (b == ChQuote)
                    begin
                        lex_mode = MODE_TSTR;
                        quotes   = 2'd0;
                    end
                    else
                    begin
                        add_mark(KIND_TEXT);
                        begin_token(b);
                    end
                MODE_STR:
                    if (b == ChQuote)
                    begin
                        add_mark(KIND_TEXT);
                        lex_mode = MODE_IDLE;
                    end
                    else if (b == ChLf)
                        add_error(ERR_UNTERM);
                    else
                        add_byte(KIND_TEXT, b);
                MODE_TSTR:
                    // Hold up to three quotes back; a further quote is content.
                    if (b == ChQuote)
                    begin
                        if (quotes < 2'd3)
                            quotes = quotes + 2'd1;
                        else
                            add_byte(KIND_TEXT, ChQuote);
                    end
                    else if (quotes == 2'd3)
                    begin
                        add_mark(KIND_TEXT);
                        quotes = 2'd0;
                        begin_token(b);
                    end
                    else
                    begin
                        repeat (quotes) add_byte(KIND_TEXT, ChQuote);
                        quotes = 2'd0;
                        add_byte(KIND_TEXT, b);
                    end
                MODE_BANG, MODE_BANGWS:
                    if (lex_mode == MODE_BANG && b == ChEqual)
                    begin
                        add_mark(KIND_NEQ);
                        lex_mode = MODE_IDLE;
                    end
                    else if (blank(b))
                        lex_mode = MODE_BANGWS;
                    else if (b == ChLBrace)
                        lex_mode = drop_cmt ? MODE_CMTDROP : MODE_CMT;
                    else
                        add_error(ERR_BANG);
                MODE_CMT:
                    if (b == ChRBrace)
                    begin
                        add_mark(KIND_COMMENT);
                        lex_mode = MODE_IDLE;
                    end
                    else
                        add_byte(KIND_COMMENT, b);
                MODE_CMTDROP:
                    if (b == ChRBrace)
                        lex_mode = MODE_IDLE;
                MODE_PLUS, MODE_MINUS:
                    if (b != ChEqual)
                        add_error(ERR_INVALID);
                    else
                    begin
                        if (lex_mode == MODE_PLUS)
                            add_mark(KIND_PLUSEQ);
                        else
                            add_mark(KIND_MINUSEQ);
                        lex_mode = MODE_IDLE;
                    end
                default:
                    begin_token(b);
            endcase
        endfunction

        // Close whatever is open, emit the end token and clear all lexer state.
        function void close_text();
            if (!halted)
            begin
                case (lex_mode)
                    MODE_ID:                add_mark(KIND_ID);
                    MODE_EQ:                add_mark(KIND_EQ);
                    MODE_Q2:                add_mark(KIND_TEXT);
                    MODE_Q1, MODE_STR:      add_error(ERR_UNTERM);
                    MODE_TSTR:
                        if (quotes == 2'd3)
                            add_mark(KIND_TEXT);
                        else
                            add_error(ERR_UNTERM);
                    MODE_BANG, MODE_BANGWS: add_error(ERR_BANG);
                    MODE_CMT:               add_mark(KIND_COMMENT);
                    MODE_PLUS, MODE_MINUS:  add_error(ERR_INVALID);
                    default:                ;
                endcase
            end
            add_mark(KIND_END);
            lex_mode = MODE_IDLE;
            quotes   = 2'd0;
            halted   = 1'b0;
        endfunction

        // Note one accepted input word and queue the result words it owes.
        function void note_byte(logic [7:0] b, logic eot);
            lex_result_t r;
            word_q.delete();
            if (eot || b == ChNul)
            begin
                close_text();
                live_words++;
            end
            else if (!halted)
            begin
                take_byte(b);
                live_words++;
            end
            if (word_q.size() > 0)
            begin
                r = word_q.pop_back();
                r.last = 1'b1;
                word_q.push_back(r);
            end
            foreach (word_q[i])
                expected_tokens.push_back(word_q[i]);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        // Check one accepted result word against the oldest prediction.
        function void check_token(logic [3:0] kind, logic has, logic [7:0] ch, logic tend,
                                  logic [1:0] err, logic last);
            lex_result_t e;
            if (expected_tokens.size() == 0)
            begin
                errors++;
                $display("%0t: result kind %0d char %0d arrived with none expected",
                         $time, kind, ch);
                return;
            end
            e = expected_tokens.pop_front();
            compare_field("token_kind", 8'(e.kind), 8'(kind));
            compare_field("has_char", 8'(e.has), 8'(has));
            compare_field("char_value", e.ch, ch);
            compare_field("token_end", 8'(e.tend), 8'(tend));
            compare_field("error_code", 8'(e.err), 8'(err));
            compare_field("last_of_run", 8'(e.last), 8'(last));
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_wdata;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] char_byte;
    logic       end_of_text;
    logic       out_valid;
    logic       out_ready;
    logic [3:0] token_kind;
    logic       has_char;
    logic [7:0] char_value;
    logic       token_end;
    logic [1:0] error_code;
    logic       last_of_run;

    token_scoreboard sb;
    bit tx_idle;     // sender inserts random gaps
    bit rx_idle;     // receiver inserts random stalls
    bit hold_req;    // ask the receiver for one long hold-off
    int idle_cycles;

    markup_token_lexer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_byte   (char_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .token_kind  (token_kind),
        .has_char    (has_char),
        .char_value  (char_value),
        .token_end   (token_end),
        .error_code  (error_code),
        .last_of_run (last_of_run)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rand_letter();
        int l;
        l = $urandom_range(0, 51);
        return (l < 26) ? 8'(8'h41 + l) : 8'(8'h61 + l - 26);
    endfunction

    // Random content byte, never zero, never the closing byte; newline only if allowed.
    function automatic logic [7:0] rand_body(logic [7:0] stop, bit allow_lf);
        logic [7:0] b;
        do
        begin
            if ($urandom_range(0, 3) != 0)
                b = 8'($urandom_range(32, 126));
            else
                b = 8'($urandom_range(1, 255));
        end
        while (b == stop || (!allow_lf && b == ChLf));
        return b;
    endfunction

    // Offer one word and hold it until accepted; return on the falling edge after.
    task automatic send_word(input logic [7:0] b, input logic eot);
        int gap;
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    = 1'b1;
        char_byte   = b;
        end_of_text = eot;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_byte(b, eot);
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    // End of text, either by the flag with a junk byte or by a zero byte.
    task automatic send_eot();
        if ($urandom_range(0, 1) != 0)
            send_word(8'($urandom_range(0, 255)), 1'b1);
        else
            send_word(ChNul, 1'b0);
    endtask

    // Drop valid, wait for every owed word, then let the front settle.
    task automatic drain();
        in_valid = 1'b0;
        while (sb.expected_tokens.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_drop(input logic v);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we      = 1'b0;
        sb.drop_cmt = v;
    endtask

    // One random token: mostly well formed, some broken, some end of text.
    task automatic send_random_token();
        logic [7:0] marks[6];
        int pick;
        int n;
        int i;
        marks = '{ChLBrace, ChRBrace, ChLBrack, ChRBrack, ChHash, ChBar};
        pick  = $urandom_range(0, 99);
        if (pick < 18)
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_word(rand_letter(), 1'b0);
        end
        else if (pick < 28)
            send_word(marks[$urandom_range(0, 5)], 1'b0);
        else if (pick < 40)
        begin
            case ($urandom_range(0, 4))
                0:       send_word(ChEqual, 1'b0);
                1:       send_word(ChEqual, 1'b0);
                2:       send_word(ChBang, 1'b0);
                3:       send_word(ChPlus, 1'b0);
                default: send_word(ChMinus, 1'b0);
            endcase
            if (pick != 28)
                send_word(ChEqual, 1'b0);
        end
        else if (pick < 50)
        begin
            n = $urandom_range(1, 3);
            repeat (n) send_word(($urandom_range(0, 5) == 5) ? 8'h20
                                 : 8'($urandom_range(9, 13)), 1'b0);
        end
        else if (pick < 62)
        begin
            send_word(ChQuote, 1'b0);
            n = $urandom_range(0, 5);
            repeat (n) send_word(rand_body(ChQuote, 1'b0), 1'b0);
            send_word(ChQuote, 1'b0);
        end
        else if (pick < 72)
        begin
            // Triple-quoted: content with stray quotes, closed by three or four.
            repeat (3) send_word(ChQuote, 1'b0);
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++)
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 2)) send_word(ChQuote, 1'b0);
                else
                    repeat ($urandom_range(1, 3)) send_word(rand_body(ChQuote, 1'b1), 1'b0);
            repeat ($urandom_range(0, 3) == 0 ? 4 : 3) send_word(ChQuote, 1'b0);
        end
        else if (pick < 82)
        begin
            send_word(ChBang, 1'b0);
            n = $urandom_range(0, 2);
            repeat (n) send_word(8'h20, 1'b0);
            send_word(ChLBrace, 1'b0);
            n = $urandom_range(0, 6);
            repeat (n) send_word(rand_body(ChRBrace, 1'b1), 1'b0);
            send_word(ChRBrace, 1'b0);
        end
        else if (pick < 88)
        begin
            send_word(ChQuote, 1'b0);
            send_word(ChQuote, 1'b0);
        end
        else if (pick < 95)
        begin
            // Broken sequences; most are followed by end of text to leave the halt.
            case ($urandom_range(0, 6))
                0:
                begin
                    send_word($urandom_range(0, 1) ? ChPlus : ChMinus, 1'b0);
                    send_word(rand_letter(), 1'b0);
                end
                1:
                begin
                    send_word(ChBang, 1'b0);
                    send_word(rand_letter(), 1'b0);
                end
                2:
                begin
                    send_word(ChQuote, 1'b0);
                    send_word(rand_body(ChQuote, 1'b0), 1'b0);
                    send_word(ChLf, 1'b0);
                end
                3:
                    send_word(8'($urandom_range(1, 255)), 1'b0);
                4:
                begin
                    send_word(ChBang, 1'b0);
                    send_word(ChLBrace, 1'b0);
                    send_word(rand_body(ChRBrace, 1'b1), 1'b0);
                    send_eot();
                end
                5:
                begin
                    repeat (3) send_word(ChQuote, 1'b0);
                    send_word(rand_body(ChQuote, 1'b1), 1'b0);
                    repeat ($urandom_range(0, 2)) send_word(ChQuote, 1'b0);
                    send_eot();
                end
                default:
                begin
                    case ($urandom_range(0, 4))
                        0:       send_word(ChBang, 1'b0);
                        1:       send_word(ChQuote, 1'b0);
                        2:       send_word(ChPlus, 1'b0);
                        3:       send_word(ChEqual, 1'b0);
                        default: send_word(ChMinus, 1'b0);
                    endcase
                    send_eot();
                end
            endcase
            if ($urandom_range(0, 1) != 0)
                send_eot();
        end
        else
            send_eot();
        if ($urandom_range(0, 9) < 4)
            send_word(8'h20, 1'b0);
    endtask

    task automatic run_random(input int words);
        int start;
        start = sb.live_words;
        while (sb.live_words - start < words)
            send_random_token();
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        int gap;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (LongHold) @(negedge clk);
                hold_req = 1'b0;
            end
            gap = rx_idle ? pick_gap() : 0;
            if (gap > 0)
            begin
                out_ready = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
                out_ready = 1'b1;
        end
    end

    // Check every accepted result word at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_token(token_kind, has_char, char_value, token_end, error_code,
                           last_of_run);
    end

    // Watchdog: end the run when no word moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IdleLimit)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        sb          = new();
        idle_cycles = 0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = 1'b0;
        in_valid    = 1'b0;
        char_byte   = 8'h00;
        end_of_text = 1'b0;
        tx_idle     = 1'b1;
        rx_idle     = 1'b1;
        hold_req    = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Directed: every single token, operators, delimiting bytes, triple quotes
        // with held-back and extra quotes, comments, each error and both end forms.
        write_drop(1'b0);
        send_text("Az{}[]#|=x==!=+=-=");
        send_word(8'hFF, 1'b1);
        send_text("\"\"\"q\"\"b\"\"\"\"\n\"\"x");
        send_word(ChNul, 1'b0);
        send_text("!{c}\"a\nk");
        send_word(8'h80, 1'b1);
        send_text("! x");
        send_word(ChNul, 1'b1);
        send_text("-");
        send_word(8'h5A, 1'b1);
        drain();

        // Comments dropped, with and without whitespace after the bang.
        write_drop(1'b1);
        send_text("!{gone}!\t{x}=");
        send_word(ChNul, 1'b1);
        run_random(110);
        drain();

        // Comments kept; first a stretch with no idling on either side.
        write_drop(1'b0);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        run_random(60);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        run_random(60);
        drain();

        // Back up the run queue: hold the receiver off while letters stream in.
        write_drop(1'b1);
        send_eot();
        tx_idle  = 1'b0;
        hold_req = 1'b1;
        repeat (24) send_word(rand_letter(), 1'b0);
        send_word(ChLBrack, 1'b0);
        tx_idle = 1'b1;
        run_random(100);
        send_eot();
        drain();

        if (sb.errors == 0 && sb.expected_tokens.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
